/* rtl/kmt_pkg.sv */
// shared types, codes and helpers of the keyed mapping table
package kmt_pkg;

    // default table size and fixed field widths
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int CNT_OUT_W       = 6;
    localparam logic [15:0] DEFAULT_CURVE = 16'd16384;

    // operation codes
    localparam logic [2:0] OP_SET_TARGET = 3'd0;
    localparam logic [2:0] OP_SET_CURVE  = 3'd1;
    localparam logic [2:0] OP_DELETE     = 3'd2;
    localparam logic [2:0] OP_CLEAR_PORT = 3'd3;
    localparam logic [2:0] OP_FIND       = 3'd4;
    localparam logic [2:0] OP_READ_INDEX = 3'd5;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd6;

    // action types
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_PITCH_BEND = 3'd3;
    localparam logic [2:0] ACT_MOD_WHEEL  = 3'd4;
    localparam logic [2:0] ACT_KEYBOARD   = 3'd5;

    // reply status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // result kinds
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    // command beat
    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [7:0]         param_id;
        logic [2:0]         action_type;
        logic [7:0]         data1;
        logic [7:0]         data2;
        logic signed [15:0] curve_word;
        logic [4:0]         entry_index;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic                 kind;
        logic [2:0]           out_type;
        logic [7:0]           out_data1;
        logic [7:0]           out_data2;
        logic signed [15:0]   out_curve;
        logic                 found;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 last;
    } result_t;

    // one stored table slot
    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  param;
        logic [2:0]  etype;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [15:0] curve;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // datapath commands issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN_KEY,
        DP_SCAN_CNT,
        DP_SCAN_REL,
        DP_APPLY,
        DP_MOVE_WR,
        DP_RD_IDX,
        DP_IDX_DONE,
        DP_PORT_SET,
        DP_PORT_RD,
        DP_PORT_CHK,
        DP_PORT_MOVE,
        DP_REPLY
    } dp_op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       scan_done;
        logic       hit;
        logic       port_more;
        logic       port_match;
    } status_t;

    // apply a new target to a slot, with the per-type byte rules
    function automatic entry_t fill_target(entry_t e, logic [2:0] t,
                                           logic [7:0] d1, logic [7:0] d2);
        entry_t r;
        r       = e;
        r.etype = t;
        r.data1 = d1;
        r.data2 = d2;
        priority if (t == ACT_PITCH_BEND)
            r.data2 = 8'd0;
        else if (t == ACT_MOD_WHEEL)
            r.data2 = 8'd1;
        else if (t == ACT_NONE || t > ACT_KEYBOARD)
        begin
            r.etype = ACT_NONE;
            r.data1 = 8'd0;
            r.data2 = 8'd0;
        end
        if (r.curve == 16'd0)
            r.curve = DEFAULT_CURVE;
        return r;
    endfunction

endpackage

/* rtl/kmt_ram.sv */
// generic single write port ram with registered read
module kmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/kmt_ctrl.sv */
// sequencing state machine of the keyed mapping table
module kmt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  kmt_pkg::status_t stat,
    output kmt_pkg::dp_op_t  dp_op,
    output logic             busy
);
    import kmt_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'h0001,
        S_DISPATCH  = 14'h0002,
        S_SCAN_KEY  = 14'h0004,
        S_APPLY     = 14'h0008,
        S_MOVE_WR   = 14'h0010,
        S_RD_IDX    = 14'h0020,
        S_IDX_DONE  = 14'h0040,
        S_SCAN_CNT  = 14'h0080,
        S_PORT_SET  = 14'h0100,
        S_PORT_RD   = 14'h0200,
        S_PORT_CHK  = 14'h0400,
        S_PORT_MOVE = 14'h0800,
        S_SCAN_REL  = 14'h1000,
        S_REPLY     = 14'h2000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        dp_op      = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_op      = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.opcode)
                    OP_SET_TARGET, OP_SET_CURVE, OP_DELETE, OP_FIND:
                        state_next = S_SCAN_KEY;
                    OP_CLEAR_PORT: state_next = S_SCAN_CNT;
                    OP_READ_INDEX: state_next = S_RD_IDX;
                    OP_CLEAR_ALL:  state_next = S_SCAN_REL;
                    default:       state_next = S_REPLY;
                endcase
            end
            S_SCAN_KEY:
            begin
                dp_op = DP_SCAN_KEY;
                if (stat.scan_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                dp_op = DP_APPLY;
                if (stat.opcode == OP_DELETE && stat.hit)
                    state_next = S_MOVE_WR;
                else
                    state_next = S_REPLY;
            end
            S_MOVE_WR:
            begin
                dp_op      = DP_MOVE_WR;
                state_next = S_REPLY;
            end
            S_RD_IDX:
            begin
                dp_op      = DP_RD_IDX;
                state_next = S_IDX_DONE;
            end
            S_IDX_DONE:
            begin
                dp_op      = DP_IDX_DONE;
                state_next = S_REPLY;
            end
            S_SCAN_CNT:
            begin
                dp_op = DP_SCAN_CNT;
                if (stat.scan_done)
                    state_next = S_PORT_SET;
            end
            S_PORT_SET:
            begin
                dp_op      = DP_PORT_SET;
                state_next = S_PORT_RD;
            end
            S_PORT_RD:
            begin
                dp_op = DP_PORT_RD;
                if (stat.port_more)
                    state_next = S_PORT_CHK;
                else
                    state_next = S_REPLY;
            end
            S_PORT_CHK:
            begin
                dp_op = DP_PORT_CHK;
                if (stat.port_match)
                    state_next = S_PORT_MOVE;
                else
                    state_next = S_PORT_RD;
            end
            S_PORT_MOVE:
            begin
                dp_op      = DP_PORT_MOVE;
                state_next = S_PORT_RD;
            end
            S_SCAN_REL:
            begin
                dp_op = DP_SCAN_REL;
                if (stat.scan_done)
                    state_next = S_REPLY;
            end
            S_REPLY:
            begin
                dp_op      = DP_REPLY;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/kmt_dpath.sv */
// slot store, scan pointer, bookkeeping and result register
module kmt_dpath #(
    parameter int TABLE_DEPTH = kmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  kmt_pkg::dp_op_t  dp_op,
    input  kmt_pkg::cmd_t    cmd,
    output kmt_pkg::status_t stat,
    output logic             strobe,
    output kmt_pkg::result_t result
);
    import kmt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] final_reg, final_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           hit_ent_reg, hit_ent_next;
    logic [CNT_W-1:0] match_cnt_reg, match_cnt_next;
    logic             rep_vld_reg, rep_vld_next;
    entry_t           rep_ent_reg, rep_ent_next;
    logic [1:0]       status_reg, status_next;
    logic             strobe_reg, strobe_next;
    result_t          res_reg, res_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_ent;

    logic             more;
    logic             key_eq;
    logic             port_eq;
    logic             key_hit;
    logic             scan_end;
    logic             is_scan;
    logic             idx_ok;
    logic [CNT_W-1:0] live_m1;
    entry_t           new_base;
    entry_t           new_ent;
    entry_t           tgt_ent;
    entry_t           crv_ent;
    logic             rel_emit;
    entry_t           rel_ent;
    logic             rep_emit;

    // slot store
    kmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent = entry_t'(ram_rdata);

    // key compares and scan bookkeeping
    assign more     = (ptr_reg < live_reg);
    assign key_eq   = (rd_ent.row == cmd_reg.row) && (rd_ent.col == cmd_reg.col)
                      && (rd_ent.param == cmd_reg.param_id);
    assign port_eq  = (rd_ent.row == cmd_reg.row) && (rd_ent.col == cmd_reg.col);
    assign key_hit  = (dp_op == DP_SCAN_KEY) && chk_vld_reg && key_eq;
    assign scan_end = !chk_vld_reg && !more;
    assign is_scan  = (dp_op == DP_SCAN_KEY) || (dp_op == DP_SCAN_CNT)
                      || (dp_op == DP_SCAN_REL);
    assign idx_ok   = (CMP_W'(cmd_reg.entry_index) < CMP_W'(live_reg));
    assign live_m1  = live_reg - 1'b1;

    // candidate slot contents
    always_comb
    begin
        new_base       = hit_ent_reg;
        new_base.row   = cmd_reg.row;
        new_base.col   = cmd_reg.col;
        new_base.param = cmd_reg.param_id;
        new_base.curve = DEFAULT_CURVE;
    end

    assign new_ent = fill_target(new_base, cmd_reg.action_type,
                                 cmd_reg.data1, cmd_reg.data2);
    assign tgt_ent = fill_target(hit_ent_reg, cmd_reg.action_type,
                                 cmd_reg.data1, cmd_reg.data2);

    always_comb
    begin
        crv_ent       = hit_ent_reg;
        crv_ent.curve = cmd_reg.curve_word;
    end

    // command execution
    always_comb
    begin
        cmd_next       = cmd_reg;
        live_next      = live_reg;
        final_next     = final_reg;
        ptr_next       = ptr_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_ent_next   = hit_ent_reg;
        match_cnt_next = match_cnt_reg;
        rep_vld_next   = rep_vld_reg;
        rep_ent_next   = rep_ent_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = rd_ent;
        ram_raddr      = ptr_reg[IDX_W-1:0];
        rel_emit       = 1'b0;
        rel_ent        = rd_ent;
        rep_emit       = 1'b0;

        // pipelined scan: address one slot, check the one read last cycle
        if (is_scan)
        begin
            if (more)
            begin
                ptr_next     = ptr_reg + 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = ptr_reg[IDX_W-1:0];
            end
            else
                chk_vld_next = 1'b0;
        end

        unique case (dp_op)
            DP_NOP: ;
            DP_LOAD:
            begin
                cmd_next       = cmd;
                ptr_next       = '0;
                chk_vld_next   = 1'b0;
                hit_next       = 1'b0;
                match_cnt_next = '0;
                rep_vld_next   = 1'b0;
                status_next    = ST_OK;
                final_next     = (cmd.opcode == OP_CLEAR_ALL) ? '0 : live_reg;
            end
            DP_SCAN_KEY:
            begin
                if (key_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = chk_idx_reg;
                    hit_ent_next = rd_ent;
                end
            end
            DP_SCAN_CNT:
            begin
                if (chk_vld_reg && port_eq)
                    match_cnt_next = match_cnt_reg + 1'b1;
            end
            DP_SCAN_REL:
            begin
                rel_emit = chk_vld_reg && (rd_ent.etype != ACT_NONE);
            end
            DP_APPLY:
            begin
                unique case (cmd_reg.opcode)
                    OP_SET_TARGET:
                    begin
                        priority if (hit_reg)
                        begin
                            rel_emit     = (hit_ent_reg.etype != ACT_NONE);
                            rel_ent      = hit_ent_reg;
                            ram_we       = 1'b1;
                            ram_wdata    = tgt_ent;
                            rep_vld_next = 1'b1;
                            rep_ent_next = tgt_ent;
                        end
                        else if (live_reg < DEPTH_CNT)
                        begin
                            ram_we       = 1'b1;
                            ram_waddr    = live_reg[IDX_W-1:0];
                            ram_wdata    = new_ent;
                            live_next    = live_reg + 1'b1;
                            final_next   = live_reg + 1'b1;
                            rep_vld_next = 1'b1;
                            rep_ent_next = new_ent;
                        end
                        else
                            status_next = ST_FULL;
                    end
                    OP_SET_CURVE:
                    begin
                        if (hit_reg)
                        begin
                            ram_we       = 1'b1;
                            ram_wdata    = crv_ent;
                            rep_vld_next = 1'b1;
                            rep_ent_next = crv_ent;
                        end
                        else
                            status_next = ST_NOT_FOUND;
                    end
                    OP_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            rel_emit   = (hit_ent_reg.etype != ACT_NONE);
                            rel_ent    = hit_ent_reg;
                            ram_raddr  = live_m1[IDX_W-1:0];
                            final_next = live_m1;
                        end
                        else
                            status_next = ST_NOT_FOUND;
                    end
                    OP_FIND:
                    begin
                        if (hit_reg)
                        begin
                            rep_vld_next = 1'b1;
                            rep_ent_next = hit_ent_reg;
                        end
                        else
                            status_next = ST_NOT_FOUND;
                    end
                    default: ;
                endcase
            end
            DP_MOVE_WR:
            begin
                // last slot moves into the freed one
                ram_we    = 1'b1;
                live_next = live_m1;
            end
            DP_RD_IDX:
            begin
                ram_raddr = IDX_W'(cmd_reg.entry_index);
            end
            DP_IDX_DONE:
            begin
                if (idx_ok)
                begin
                    hit_next     = 1'b1;
                    rep_vld_next = 1'b1;
                    rep_ent_next = rd_ent;
                end
                else
                    status_next = ST_NOT_FOUND;
            end
            DP_PORT_SET:
            begin
                final_next  = live_reg - match_cnt_reg;
                ptr_next    = '0;
                status_next = ST_NOT_FOUND;
            end
            DP_PORT_RD: ;
            DP_PORT_CHK:
            begin
                if (port_eq)
                begin
                    rel_emit    = (rd_ent.etype != ACT_NONE);
                    hit_next    = 1'b1;
                    status_next = ST_OK;
                    ram_raddr   = live_m1[IDX_W-1:0];
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            DP_PORT_MOVE:
            begin
                // same slot is checked again after the move
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[IDX_W-1:0];
                live_next = live_m1;
            end
            DP_REPLY:
            begin
                rep_emit = 1'b1;
                if (cmd_reg.opcode == OP_CLEAR_ALL)
                    live_next = '0;
            end
            default: ;
        endcase
    end

    // result beat assembly
    always_comb
    begin
        res_next    = res_reg;
        strobe_next = rel_emit || rep_emit;
        if (rep_emit)
        begin
            res_next.kind        = KIND_REPLY;
            res_next.out_type    = rep_vld_reg ? rep_ent_reg.etype : ACT_NONE;
            res_next.out_data1   = rep_vld_reg ? rep_ent_reg.data1 : 8'd0;
            res_next.out_data2   = rep_vld_reg ? rep_ent_reg.data2 : 8'd0;
            res_next.out_curve   = rep_vld_reg ? rep_ent_reg.curve : 16'd0;
            res_next.found       = hit_reg;
            res_next.status      = status_reg;
            res_next.entry_count = CNT_OUT_W'(final_next);
            res_next.last        = 1'b1;
        end
        else if (rel_emit)
        begin
            res_next.kind        = KIND_RELEASE;
            res_next.out_type    = rel_ent.etype;
            res_next.out_data1   = rel_ent.data1;
            res_next.out_data2   = rel_ent.data2;
            res_next.out_curve   = 16'sd0;
            res_next.found       = 1'b0;
            res_next.status      = ST_OK;
            res_next.entry_count = CNT_OUT_W'(final_next);
            res_next.last        = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            chk_vld_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            live_reg    <= live_next;
            chk_vld_reg <= chk_vld_next;
            strobe_reg  <= strobe_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        final_reg     <= final_next;
        ptr_reg       <= ptr_next;
        chk_idx_reg   <= chk_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_ent_reg   <= hit_ent_next;
        match_cnt_reg <= match_cnt_next;
        rep_vld_reg   <= rep_vld_next;
        rep_ent_reg   <= rep_ent_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
    end

    // status towards the controller
    assign stat.opcode     = cmd_reg.opcode;
    assign stat.scan_done  = scan_end || key_hit;
    assign stat.hit        = hit_reg;
    assign stat.port_more  = more;
    assign stat.port_match = port_eq;

    assign strobe = strobe_reg;
    assign result = res_reg;

`ifndef SYNTH
    // live count never exceeds the table
    assert property (@(posedge clk) disable iff (!rst_n) live_reg <= DEPTH_CNT)
        else $error("live count beyond table depth");

    // live count moves by one, or drops to empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg == $past(live_reg)) || (live_reg == $past(live_reg) + 1)
        || (live_reg == $past(live_reg) - 1) || (live_reg == 0))
        else $error("live count jumped");

    // only the reply beat is marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (res_reg.kind == res_reg.last))
        else $error("kind and last disagree");

    // release beats carry no curve, found or status
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (res_reg.kind == KIND_RELEASE)) |->
        ((res_reg.out_curve == 16'sd0) && !res_reg.found && (res_reg.status == ST_OK)))
        else $error("release beat with reply fields");
`endif

endmodule

/* rtl/keyed_mapping_table.sv */
// Keyed mapping table: up to TABLE_DEPTH entries keyed by row, column and parameter
// id, held in one single-port-write RAM and searched by a linear scan that reads
// one slot per cycle. A command is taken when start is high and busy is low;
// busy stays high until the final reply has been launched. Each result beat is
// shown on result for one cycle with strobe high and cannot be held off. Release
// beats for removed or overwritten entries come first, the reply (last set)
// always comes last. Set target, set curve, delete and find stop the scan at the
// first match; clear port first counts the matching slots, then walks the table,
// moving the last slot into each removed one. There is no clearing pass after
// reset.
module keyed_mapping_table #(
    parameter int TABLE_DEPTH = kmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kmt_pkg::cmd_t    cmd,
    output logic             strobe,
    output kmt_pkg::result_t result
);
    import kmt_pkg::*;

    dp_op_t  dp_op;
    status_t stat;

    // sequencer
    kmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .dp_op (dp_op),
        .busy  (busy)
    );

    // table store and result register
    kmt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .dp_op  (dp_op),
        .cmd    (cmd),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

endmodule
